### rtl/ggbfs_pkg.sv
// Shared types, codes and helpers for the greedy best-first grid search block.
package ggbfs_pkg;

	localparam int GRID_DIM_DEF   = 64;
	localparam int OPEN_DEPTH_DEF = 4096;
	localparam int CRD_W          = 7;
	localparam int DIST_W         = 8;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 7;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_RESTART,
		KIND_STEP,
		KIND_NOP
	} kind_t;

	typedef enum logic [1:0] {
		ST_LOOK,
		ST_GOAL,
		ST_UNREACH,
		ST_DONE
	} stat_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAP_W,
		CFG_MAP_H,
		CFG_START_X,
		CFG_START_Y,
		CFG_GOAL_X,
		CFG_GOAL_Y
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_DISP,
		S_RCLR,
		S_RSET,
		S_POP,
		S_POPW,
		S_GOAL,
		S_NB,
		S_NBW,
		S_SCAN,
		S_SCANW,
		S_DEC,
		S_SHR,
		S_SHW,
		S_NXT,
		S_R_LOOK,
		S_R_GOAL,
		S_R_UNR,
		S_R_DONE
	} state_t;

	typedef struct packed {
		kind_t      kind;
		logic [5:0] cell_x;
		logic [5:0] cell_y;
		logic       obstacle;
	} in_item_t;

	typedef struct packed {
		stat_t      status;
		logic [5:0] node_x;
		logic [5:0] node_y;
		logic [5:0] parent_x;
		logic [5:0] parent_y;
	} out_item_t;

	typedef struct packed {
		logic [6:0] map_width;
		logic [6:0] map_height;
		logic [5:0] start_x;
		logic [5:0] start_y;
		logic [5:0] goal_x;
		logic [5:0] goal_y;
	} cfg_t;

	typedef struct packed {
		logic [CRD_W-1:0] x;
		logic [CRD_W-1:0] y;
		logic [CRD_W-1:0] px;
		logic [CRD_W-1:0] py;
	} ent_t;

	typedef struct packed {
		logic  latch_in;
		logic  obs_wr;
		logic  clr_wr;
		logic  clr_obs;
		logic  rst_list;
		logic  pop_rd;
		logic  pop_take;
		logic  vis_mark;
		logic  nb_first;
		logic  nb_next;
		logic  scan_first;
		logic  scan_rd;
		logic  scan_next;
		logic  pos_from_i;
		logic  pos_from_cnt;
		logic  sh_init;
		logic  sh_rd;
		logic  sh_wr;
		logic  ins_wr;
		logic  res_load;
		stat_t res_status;
	} ctl_cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  clr_last;
		logic  cnt_zero;
		logic  is_goal;
		logic  nb_ok;
		logic  cell_free;
		logic  scan_end;
		logic  match;
		logic  less;
		logic  full;
		logic  k_gt_pos;
		logic  nb_last;
		logic  out_free;
	} dp_stat_t;

	function automatic logic [DIST_W-1:0] goal_dist(input logic [CRD_W-1:0] x,
		input logic [CRD_W-1:0] y, input logic [5:0] gx, input logic [5:0] gy);
		logic [CRD_W-1:0] gxe;
		logic [CRD_W-1:0] gye;
		logic [CRD_W-1:0] dx;
		logic [CRD_W-1:0] dy;
		gxe = CRD_W'(gx);
		gye = CRD_W'(gy);
		dx  = (x > gxe) ? x - gxe : gxe - x;
		dy  = (y > gye) ? y - gye : gye - y;
		return DIST_W'(dx) + DIST_W'(dy);
	endfunction

endpackage

### rtl/ggbfs_ctrl.sv
// Sequencer for the search block: issues datapath commands per item.
module ggbfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ggbfs_pkg::dp_stat_t stat,
	output ggbfs_pkg::ctl_cmd_t cmd
);
	import ggbfs_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR:    if (stat.clr_last) state_d = S_IDLE;
			S_IDLE:   if (in_valid) state_d = S_DISP;
			S_DISP: begin
				case (stat.kind)
					KIND_RESTART: state_d = S_RCLR;
					KIND_STEP:    state_d = S_POP;
					default:      state_d = S_R_DONE;
				endcase
			end
			S_RCLR:   if (stat.clr_last) state_d = S_RSET;
			S_RSET:   state_d = S_R_DONE;
			S_POP:    state_d = stat.cnt_zero ? S_R_UNR : S_POPW;
			S_POPW:   state_d = S_GOAL;
			S_GOAL:   state_d = stat.is_goal ? S_R_GOAL : S_NB;
			S_NB:     state_d = stat.nb_ok ? S_NBW : S_NXT;
			S_NBW:    state_d = stat.cell_free ? S_SCAN : S_NXT;
			S_SCAN:   state_d = stat.scan_end ? S_DEC : S_SCANW;
			S_SCANW: begin
				if (stat.match) state_d = S_NXT;
				else if (stat.less) state_d = S_DEC;
				else state_d = S_SCAN;
			end
			S_DEC:    state_d = stat.full ? S_NXT : S_SHR;
			S_SHR:    state_d = stat.k_gt_pos ? S_SHW : S_NXT;
			S_SHW:    state_d = S_SHR;
			S_NXT:    state_d = stat.nb_last ? S_R_LOOK : S_NB;
			S_R_LOOK, S_R_GOAL, S_R_UNR, S_R_DONE: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.clr_wr  = 1'b1;
				cmd.clr_obs = 1'b1;
			end
			S_IDLE: begin
				in_ready     = 1'b1;
				cmd.latch_in = in_valid;
			end
			S_DISP:   cmd.obs_wr = (stat.kind == KIND_LOAD);
			S_RCLR:   cmd.clr_wr = 1'b1;
			S_RSET:   cmd.rst_list = 1'b1;
			S_POP:    cmd.pop_rd = !stat.cnt_zero;
			S_POPW:   cmd.pop_take = 1'b1;
			S_GOAL: begin
				cmd.vis_mark = 1'b1;
				cmd.nb_first = !stat.is_goal;
			end
			S_NBW:    cmd.scan_first = stat.cell_free;
			S_SCAN: begin
				cmd.pos_from_cnt = stat.scan_end;
				cmd.scan_rd      = !stat.scan_end;
			end
			S_SCANW: begin
				cmd.pos_from_i = !stat.match && stat.less;
				cmd.scan_next  = !stat.match && !stat.less;
			end
			S_DEC:    cmd.sh_init = !stat.full;
			S_SHR: begin
				cmd.sh_rd  = stat.k_gt_pos;
				cmd.ins_wr = !stat.k_gt_pos;
			end
			S_SHW:    cmd.sh_wr = 1'b1;
			S_NXT:    cmd.nb_next = !stat.nb_last;
			S_R_LOOK: begin
				cmd.res_load   = stat.out_free;
				cmd.res_status = ST_LOOK;
			end
			S_R_GOAL: begin
				cmd.res_load   = stat.out_free;
				cmd.res_status = ST_GOAL;
			end
			S_R_UNR: begin
				cmd.res_load   = stat.out_free;
				cmd.res_status = ST_UNREACH;
			end
			S_R_DONE: begin
				cmd.res_load   = stat.out_free;
				cmd.res_status = ST_DONE;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### rtl/ggbfs_dp.sv
// Datapath: cell maps, sorted open list RAM, counters and result register.
module ggbfs_dp #(
	parameter int GRID_DIM   = ggbfs_pkg::GRID_DIM_DEF,
	parameter int OPEN_DEPTH = ggbfs_pkg::OPEN_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ggbfs_pkg::cfg_t      cfg,
	input  ggbfs_pkg::ctl_cmd_t  cmd,
	output ggbfs_pkg::dp_stat_t  stat,
	input  ggbfs_pkg::in_item_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ggbfs_pkg::out_item_t out_data
);
	import ggbfs_pkg::*;

	localparam int CELLS   = GRID_DIM * GRID_DIM;
	localparam int CELL_AW = $clog2(CELLS);
	localparam int GAW     = $clog2(GRID_DIM);
	localparam int OAW     = $clog2(OPEN_DEPTH);
	localparam int CNT_W   = $clog2(OPEN_DEPTH + 1);
	localparam int MOD_N   = 2 ** CRD_W;

	// coordinate -> grid column/row, wrapping at GRID_DIM
	logic [GAW-1:0] mod_tbl [MOD_N];
	for (genvar v = 0; v < MOD_N; v++) begin : g_mod
		assign mod_tbl[v] = GAW'(v % GRID_DIM);
	end

	function automatic logic [CELL_AW-1:0] cidx(input logic [GAW-1:0] xm,
		input logic [GAW-1:0] ym);
		return CELL_AW'(ym) * CELL_AW'(GRID_DIM) + CELL_AW'(xm);
	endfunction

	function automatic logic [OAW-1:0] phys(input logic [OAW-1:0] h,
		input logic [CNT_W-1:0] l);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(h) + (CNT_W+1)'(l);
		if (s >= (CNT_W+1)'(OPEN_DEPTH)) s = s - (CNT_W+1)'(OPEN_DEPTH);
		return s[OAW-1:0];
	endfunction

	in_item_t          item_q;
	ent_t              e_q;
	ent_t              ol_rdata_q;
	logic              obs_rd_q;
	logic              vis_rd_q;
	logic [2:0]        n_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [OAW-1:0]    head_q;
	logic [CNT_W-1:0]  i_q;
	logic [CNT_W-1:0]  k_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CELL_AW-1:0] clr_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic [8:0]         w_eff;
	logic [8:0]         h_eff;
	logic               xhi;
	logic               xlo;
	logic               yhi;
	logic               ylo;
	logic [CRD_W-1:0]   nx;
	logic [CRD_W-1:0]   ny;
	logic               nb_ok;
	logic [CELL_AW-1:0] nb_idx;
	logic [CELL_AW-1:0] e_idx;
	logic [CELL_AW-1:0] st_idx;
	logic [CELL_AW-1:0] ld_idx;
	logic               clr_last;
	logic               full;

	always_comb begin
		if (cfg.map_width == '0) w_eff = 9'd1;
		else if (9'(cfg.map_width) > 9'(GRID_DIM)) w_eff = 9'(GRID_DIM);
		else w_eff = 9'(cfg.map_width);
		if (cfg.map_height == '0) h_eff = 9'd1;
		else if (9'(cfg.map_height) > 9'(GRID_DIM)) h_eff = 9'(GRID_DIM);
		else h_eff = 9'(cfg.map_height);
	end

	assign xhi = 9'(e_q.x) < (w_eff - 9'd1);
	assign yhi = 9'(e_q.y) < (h_eff - 9'd1);
	assign xlo = (e_q.x != '0);
	assign ylo = (e_q.y != '0);

	// E, SE, S, SW, W, NW, N, NE
	always_comb begin
		nx    = e_q.x;
		ny    = e_q.y;
		nb_ok = 1'b0;
		case (n_q)
			3'd0: begin nx = e_q.x + 1'b1;                    nb_ok = xhi;        end
			3'd1: begin nx = e_q.x + 1'b1; ny = e_q.y + 1'b1; nb_ok = xhi && yhi; end
			3'd2: begin                    ny = e_q.y + 1'b1; nb_ok = yhi;        end
			3'd3: begin nx = e_q.x - 1'b1; ny = e_q.y + 1'b1; nb_ok = yhi && xlo; end
			3'd4: begin nx = e_q.x - 1'b1;                    nb_ok = xlo;        end
			3'd5: begin nx = e_q.x - 1'b1; ny = e_q.y - 1'b1; nb_ok = xlo && ylo; end
			3'd6: begin                    ny = e_q.y - 1'b1; nb_ok = ylo;        end
			3'd7: begin nx = e_q.x + 1'b1; ny = e_q.y - 1'b1; nb_ok = ylo && xhi; end
			default: begin nb_ok = 1'b0; end
		endcase
	end

	assign nb_idx   = cidx(mod_tbl[nx], mod_tbl[ny]);
	assign e_idx    = cidx(mod_tbl[e_q.x], mod_tbl[e_q.y]);
	assign st_idx   = cidx(mod_tbl[CRD_W'(cfg.start_x)], mod_tbl[CRD_W'(cfg.start_y)]);
	assign ld_idx   = cidx(mod_tbl[CRD_W'(item_q.cell_x)], mod_tbl[CRD_W'(item_q.cell_y)]);
	assign clr_last = (clr_q == CELL_AW'(CELLS - 1));
	assign full     = (cnt_q == CNT_W'(OPEN_DEPTH));

	// cell maps
	logic obs_mem [CELLS];
	logic vis_mem [CELLS];

	logic               vis_we;
	logic [CELL_AW-1:0] vis_wa;
	logic               vis_wd;

	always_comb begin
		vis_we = cmd.clr_wr || cmd.rst_list || cmd.vis_mark;
		vis_wa = e_idx;
		vis_wd = 1'b1;
		if (cmd.clr_wr) begin
			vis_wa = clr_q;
			vis_wd = 1'b0;
		end else if (cmd.rst_list) begin
			vis_wa = st_idx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr && cmd.clr_obs) obs_mem[clr_q] <= 1'b0;
		else if (cmd.obs_wr) obs_mem[ld_idx] <= item_q.obstacle;
		obs_rd_q <= obs_mem[nb_idx];
	end

	always_ff @(posedge clk) begin
		if (vis_we) vis_mem[vis_wa] <= vis_wd;
		vis_rd_q <= vis_mem[nb_idx];
	end

	// open list: circular RAM, logical slot 0 at head_q
	ent_t ol_mem [OPEN_DEPTH];

	logic             ol_rd;
	logic [OAW-1:0]   ol_ra;
	logic             ol_we;
	logic [OAW-1:0]   ol_wa;
	ent_t             ol_wd;
	logic [CNT_W-1:0] rd_l;

	always_comb begin
		ol_rd = cmd.pop_rd || cmd.scan_rd || cmd.sh_rd;
		if (cmd.pop_rd) rd_l = '0;
		else if (cmd.scan_rd) rd_l = i_q;
		else rd_l = k_q - 1'b1;
		ol_ra = phys(head_q, rd_l);

		ol_we = cmd.rst_list || cmd.sh_wr || cmd.ins_wr;
		ol_wa = phys(head_q, pos_q);
		ol_wd = '{x: nx, y: ny, px: e_q.x, py: e_q.y};
		if (cmd.rst_list) begin
			ol_wa = '0;
			ol_wd = '{x: CRD_W'(cfg.start_x), y: CRD_W'(cfg.start_y),
			          px: CRD_W'(cfg.start_x), py: CRD_W'(cfg.start_y)};
		end else if (cmd.sh_wr) begin
			ol_wa = phys(head_q, k_q);
			ol_wd = ol_rdata_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ol_we) ol_mem[ol_wa] <= ol_wd;
		if (ol_rd) ol_rdata_q <= ol_mem[ol_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) item_q <= in_data;
		if (cmd.pop_take) e_q <= ol_rdata_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			head_q <= '0;
			n_q    <= '0;
			i_q    <= '0;
			k_q    <= '0;
			pos_q  <= '0;
			clr_q  <= '0;
		end else begin
			if (cmd.rst_list) begin
				head_q <= '0;
				cnt_q  <= CNT_W'(1);
			end else if (cmd.pop_take) begin
				head_q <= (head_q == OAW'(OPEN_DEPTH - 1)) ? '0 : head_q + 1'b1;
				cnt_q  <= cnt_q - 1'b1;
			end else if (cmd.ins_wr) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.nb_first) n_q <= '0;
			else if (cmd.nb_next) n_q <= n_q + 1'b1;
			if (cmd.scan_first) i_q <= '0;
			else if (cmd.scan_next) i_q <= i_q + 1'b1;
			if (cmd.pos_from_i) pos_q <= i_q;
			else if (cmd.pos_from_cnt) pos_q <= cnt_q;
			if (cmd.sh_init) k_q <= cnt_q;
			else if (cmd.sh_wr) k_q <= k_q - 1'b1;
			if (cmd.clr_wr) clr_q <= clr_last ? '0 : clr_q + 1'b1;
		end
	end

	// result register: a new beat may load while the old one leaves
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_q.status <= cmd.res_status;
			if (cmd.res_status == ST_LOOK || cmd.res_status == ST_GOAL) begin
				out_q.node_x   <= e_q.x[5:0];
				out_q.node_y   <= e_q.y[5:0];
				out_q.parent_x <= e_q.px[5:0];
				out_q.parent_y <= e_q.py[5:0];
			end else begin
				out_q.node_x   <= '0;
				out_q.node_y   <= '0;
				out_q.parent_x <= '0;
				out_q.parent_y <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign stat.kind      = item_q.kind;
	assign stat.clr_last  = clr_last;
	assign stat.cnt_zero  = (cnt_q == '0);
	assign stat.is_goal   = (e_q.x == CRD_W'(cfg.goal_x)) && (e_q.y == CRD_W'(cfg.goal_y));
	assign stat.nb_ok     = nb_ok;
	assign stat.cell_free = !obs_rd_q && !vis_rd_q;
	assign stat.scan_end  = (i_q == cnt_q);
	assign stat.match     = (ol_rdata_q.x == nx) && (ol_rdata_q.y == ny);
	assign stat.less      = goal_dist(nx, ny, cfg.goal_x, cfg.goal_y) <
	                        goal_dist(ol_rdata_q.x, ol_rdata_q.y, cfg.goal_x, cfg.goal_y);
	assign stat.full      = full;
	assign stat.k_gt_pos  = (k_q > pos_q);
	assign stat.nb_last   = (n_q == 3'd7);
	assign stat.out_free  = !out_valid_q || out_ready;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(OPEN_DEPTH))
		else $error("open list count above depth");
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_wr |-> !full)
		else $error("insert into full open list");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_take |-> (cnt_q != '0))
		else $error("pop from empty open list");
	a_res_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |=> out_valid_q)
		else $error("result beat lost");
`endif

endmodule

### rtl/grid_greedy_best_first_step_top.sv
// Greedy best-first search step engine on an 8-connected grid. After reset the
// block sweeps both cell maps clear, one cell per cycle, before taking its
// first item (configuration writes are taken throughout). One item gives one
// result beat. A load writes one obstacle cell; a restart sweeps the visited
// map clear in the same way and puts the start cell alone in the open list. A
// step pops the list head and, unless it is the goal, looks at each of the
// eight neighbours: one out of bounds, blocked or visited is skipped, any other
// is checked against the list, and every sorted insert walks the list and
// shifts its tail, one entry at a time, through the single read port of the
// open-list RAM. An empty list ends a step as unreachable. A finished result
// waits in the output register while the next item is accepted.
module grid_greedy_best_first_step_top #(
	parameter int GRID_DIM   = ggbfs_pkg::GRID_DIM_DEF,
	parameter int OPEN_DEPTH = ggbfs_pkg::OPEN_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  ggbfs_pkg::in_item_t                   in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output ggbfs_pkg::out_item_t                  out_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ggbfs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ggbfs_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ggbfs_pkg::*;

	cfg_t     cfg_q;
	ctl_cmd_t cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.map_width  <= 7'd64;
			cfg_q.map_height <= 7'd64;
			cfg_q.start_x    <= '0;
			cfg_q.start_y    <= '0;
			cfg_q.goal_x     <= '0;
			cfg_q.goal_y     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAP_W:   cfg_q.map_width  <= cfg_data;
				CFG_MAP_H:   cfg_q.map_height <= cfg_data;
				CFG_START_X: cfg_q.start_x    <= cfg_data[5:0];
				CFG_START_Y: cfg_q.start_y    <= cfg_data[5:0];
				CFG_GOAL_X:  cfg_q.goal_x     <= cfg_data[5:0];
				CFG_GOAL_Y:  cfg_q.goal_y     <= cfg_data[5:0];
				default: begin
				end
			endcase
		end
	end

	ggbfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ggbfs_dp #(
		.GRID_DIM   (GRID_DIM),
		.OPEN_DEPTH (OPEN_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
